// ===== sv/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit range allocator
// Holds opcodes, status codes, configuration register indexes, the
// controller state type and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DW         = 32;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_INIT  = 3'd0;
  localparam opcode_t OP_RESET = 3'd1;
  localparam opcode_t OP_ALLOC = 3'd2;
  localparam opcode_t OP_FREE  = 3'd3;
  localparam opcode_t OP_GROW  = 3'd4;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ZERO_SIZE  = 3'd1;
  localparam status_t ST_NO_FIT     = 3'd2;
  localparam status_t ST_LIST_FULL  = 3'd3;
  localparam status_t ST_GROW_SMALL = 3'd4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BASE_OFFSET = 2'd0;
  localparam cfg_idx_t CFG_REGION_SIZE = 2'd1;
  localparam cfg_idx_t CFG_INIT_FREE   = 2'd2;
  localparam cfg_idx_t CFG_FREE_WHOLE  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC,
    S_A_RD, S_A_WAIT, S_A_DIV, S_A_PAD, S_A_EX,
    S_E_RD, S_E_WR,
    S_F_RD, S_F_CMP,
    S_S_RD, S_S_WR,
    S_M_RD0, S_M_LD, S_M_RD, S_M_EX
  } ctrl_state_t;

  typedef enum logic [1:0] {RD_IDX, RD_WPM1, RD_ZERO} rd_sel_t;
  typedef enum logic [2:0] {WR_SINGLE, WR_ALLOC, WR_Q, WR_INS, WR_CUR} wr_sel_t;

  typedef struct packed {
    logic    latch;
    logic    set_single;
    logic    ins_ld;
    logic    idx_clr;
    logic    idx_inc;
    logic    wp_inc;
    logic    wp_dec;
    logic    erase_setup;
    logic    pos_set;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_wp1;
    logic    mrg_init;
    logic    cur_ld;
    logic    cur_merge;
    logic    div_go;
    logic    pad_ld;
    logic    alloc_upd;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    done;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t          op;
    logic             size_zero;
    logic             full;
    logic             grow_small;
    logic             delta_zero;
    logic             a_le1;
    logic             idx_end;
    logic             wp_at_pos;
    logic             div_done;
    logic             fit;
    logic             len_zero;
    logic             adjacent;
    logic             start_le;
    logic [CNT_W-1:0] cnt;
  } dp_sts_t;

endpackage

// ===== sv/ffra_rem.sv =====
// ----------------------------------------------------------------------------
// ffra_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; gives dividend mod divisor
// with a one-cycle done pulse after DW steps.
// ----------------------------------------------------------------------------
module ffra_rem
  import ffra_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int STEP_W = $clog2(DW + 1);

  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvd_r;
  logic [DW-1:0]     dsr_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [DW:0]       trial;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DW'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[DW-1:0];
    end
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(DW);
      end else if (run_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and dividend shift
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/ffra_dp.sv =====
// ----------------------------------------------------------------------------
// ffra_dp: allocator datapath
// Free-range memory, configuration registers, counters, scan pointers and
// result registers; acts on the controller's commands.
// ----------------------------------------------------------------------------
module ffra_dp
  import ffra_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  input  opcode_t       in_opcode,
  input  logic [DW-1:0] in_size,
  input  logic [DW-1:0] in_alignment,
  input  logic [DW-1:0] in_range_offset,
  input  logic [DW-1:0] in_new_total_size,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  logic [DW-1:0] cfg_wdata,
  output logic          out_valid,
  output status_t       out_status,
  output logic [DW-1:0] out_granted_offset,
  output logic [DW-1:0] out_granted_size,
  output logic          out_was_hole,
  output logic [DW-1:0] out_allocated_bytes
);

  logic [2*DW-1:0]  mem [MAX_RANGES];
  logic [2*DW-1:0]  q_r;
  logic [DW-1:0]    q_start, q_len;

  logic [DW-1:0]    base_r, rsize_r, ifree_r;
  logic             fwhole_r;
  logic [DW-1:0]    rstart_r, rlen_r, taken_r;
  logic [CNT_W-1:0] cnt_r, idx_r, wp_r, pos_r;

  opcode_t          op_r;
  logic [DW-1:0]    size_r, align_r, roff_r, newsz_r;
  logic [DW-1:0]    ins_start_r, ins_len_r;
  logic [DW-1:0]    cur_start_r, cur_len_r;
  logic [DW-1:0]    pad_r;
  logic [DW:0]      need_r;

  logic             valid_r;
  status_t          status_r;
  logic [DW-1:0]    goff_r, gsize_r;
  logic             hole_r;

  logic             div_done;
  logic [DW-1:0]    div_rem, rem_use, pad_nxt;
  logic [DW-1:0]    single_start, single_len;
  logic [DW:0]      cur_end, cur_sum;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [2*DW-1:0]  wr_data;
  logic             last;

  assign q_start = q_r[2*DW-1:DW];
  assign q_len   = q_r[DW-1:0];

  ffra_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (q_start),
    .divisor  (align_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // single range for init and reset
  always_comb begin
    if (op_r == OP_INIT) begin
      single_start = base_r;
      single_len   = fwhole_r ? rsize_r : ifree_r;
    end else begin
      single_start = rstart_r;
      single_len   = rlen_r;
    end
  end

  // alignment padding from the remainder
  assign rem_use = (align_r <= DW'(1)) ? '0 : div_rem;
  assign pad_nxt = (rem_use == '0) ? '0 : align_r - rem_use;

  assign cur_end = {1'b0, cur_start_r} + {1'b0, cur_len_r};
  assign cur_sum = {1'b0, cur_len_r} + {1'b0, q_len};
  assign last    = (idx_r + 1'b1) == cnt_r;

  // memory addresses and write data
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:  rd_addr = idx_r[IDX_W-1:0];
      RD_WPM1: rd_addr = IDX_W'(wp_r - 1'b1);
      default: rd_addr = '0;
    endcase
    case (cmd.wr_sel)
      WR_SINGLE: begin
        wr_addr = '0;
        wr_data = {single_start, single_len};
      end
      WR_ALLOC: begin
        wr_addr = idx_r[IDX_W-1:0];
        wr_data = {q_start + need_r[DW-1:0], q_len - need_r[DW-1:0]};
      end
      WR_Q: begin
        wr_addr = wp_r[IDX_W-1:0];
        wr_data = q_r;
      end
      WR_INS: begin
        wr_addr = pos_r[IDX_W-1:0];
        wr_data = {ins_start_r, ins_len_r};
      end
      default: begin
        wr_addr = wp_r[IDX_W-1:0];
        wr_data = {cur_start_r, cur_len_r};
      end
    endcase
  end

  // free-range memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // control state: configuration, region, counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      rsize_r  <= '0;
      ifree_r  <= '0;
      fwhole_r <= 1'b1;
      rstart_r <= '0;
      rlen_r   <= '0;
      taken_r  <= '0;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_OFFSET: base_r   <= cfg_wdata;
          CFG_REGION_SIZE: rsize_r  <= cfg_wdata;
          CFG_INIT_FREE:   ifree_r  <= cfg_wdata;
          CFG_FREE_WHOLE:  fwhole_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.set_single) begin
        cnt_r <= CNT_W'(single_len != '0);
        if (op_r == OP_INIT) begin
          rstart_r <= base_r;
          rlen_r   <= rsize_r;
          taken_r  <= base_r;
        end else begin
          taken_r  <= '0;
        end
      end
      if (cmd.ins_ld && op_r == OP_GROW) begin
        rlen_r <= newsz_r;
      end
      if (cmd.alloc_upd && last) begin
        taken_r <= taken_r + size_r;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
      if (cmd.cnt_wp1) cnt_r <= wp_r + 1'b1;
      valid_r <= cmd.done;
    end
  end

  // payload registers: request, pointers, working entries and results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_opcode;
      size_r  <= in_size;
      align_r <= in_alignment;
      roff_r  <= in_range_offset;
      newsz_r <= in_new_total_size;
      goff_r  <= '0;
      gsize_r <= '0;
      hole_r  <= 1'b0;
    end
    if (cmd.ins_ld) begin
      if (op_r == OP_GROW) begin
        ins_start_r <= rlen_r;
        ins_len_r   <= newsz_r - rlen_r;
      end else begin
        ins_start_r <= roff_r;
        ins_len_r   <= size_r;
      end
    end
    if (cmd.idx_clr) idx_r <= '0;
    if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    if (cmd.wp_inc)  wp_r  <= wp_r + 1'b1;
    if (cmd.wp_dec)  wp_r  <= wp_r - 1'b1;
    if (cmd.erase_setup) begin
      wp_r  <= idx_r;
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.pos_set) begin
      pos_r <= idx_r;
      wp_r  <= cnt_r;
    end
    if (cmd.mrg_init) begin
      idx_r <= CNT_W'(1);
      wp_r  <= '0;
    end
    if (cmd.cur_ld) begin
      cur_start_r <= q_start;
      cur_len_r   <= q_len;
    end
    if (cmd.cur_merge) begin
      cur_len_r <= cur_sum[DW-1:0];
    end
    if (cmd.pad_ld) begin
      pad_r  <= pad_nxt;
      need_r <= {1'b0, size_r} + {1'b0, pad_nxt};
    end
    if (cmd.alloc_upd) begin
      goff_r  <= q_start + pad_r;
      gsize_r <= size_r;
      hole_r  <= !last;
    end
    if (cmd.done) begin
      status_r <= cmd.status;
    end
  end

  // status toward the controller
  always_comb begin
    sts.op         = op_r;
    sts.size_zero  = size_r == '0;
    sts.full       = cnt_r >= CNT_W'(MAX_RANGES);
    sts.grow_small = newsz_r < rlen_r;
    sts.delta_zero = newsz_r == rlen_r;
    sts.a_le1      = align_r <= DW'(1);
    sts.idx_end    = idx_r == cnt_r;
    sts.wp_at_pos  = wp_r == pos_r;
    sts.div_done   = div_done;
    sts.fit        = need_r <= {1'b0, q_len};
    sts.len_zero   = q_len == need_r[DW-1:0];
    sts.adjacent   = (cur_end == {1'b0, q_start}) && !cur_sum[DW];
    sts.start_le   = q_start <= ins_start_r;
    sts.cnt        = cnt_r;
  end

  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_granted_offset  = goff_r;
  assign out_granted_size    = gsize_r;
  assign out_was_hole        = hole_r;
  assign out_allocated_bytes = taken_r;

endmodule

// ===== sv/ffra_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffra_ctrl: allocator controller
// Sequences each request: decode, first-fit scan, erase shift, ordered
// insert with shift-up, and the coalescing pass over the list.
// ----------------------------------------------------------------------------
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_INIT, OP_RESET: begin
            cmd.set_single = 1'b1;
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_SINGLE;
            cmd.done       = 1'b1;
            cmd.status     = ST_OK;
            state_nxt      = S_IDLE;
          end
          OP_ALLOC: begin
            if (sts.size_zero) begin
              cmd.done   = 1'b1;
              cmd.status = ST_ZERO_SIZE;
              state_nxt  = S_IDLE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_A_RD;
            end
          end
          OP_FREE: begin
            if (sts.size_zero) begin
              cmd.done   = 1'b1;
              cmd.status = ST_ZERO_SIZE;
              state_nxt  = S_IDLE;
            end else if (sts.full) begin
              cmd.done   = 1'b1;
              cmd.status = ST_LIST_FULL;
              state_nxt  = S_IDLE;
            end else begin
              cmd.ins_ld  = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_F_RD;
            end
          end
          OP_GROW: begin
            if (sts.grow_small) begin
              cmd.done   = 1'b1;
              cmd.status = ST_GROW_SMALL;
              state_nxt  = S_IDLE;
            end else if (sts.delta_zero) begin
              cmd.done   = 1'b1;
              cmd.status = ST_OK;
              state_nxt  = S_IDLE;
            end else if (sts.full) begin
              cmd.done   = 1'b1;
              cmd.status = ST_LIST_FULL;
              state_nxt  = S_IDLE;
            end else begin
              cmd.ins_ld  = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_F_RD;
            end
          end
          default: begin
            cmd.done   = 1'b1;
            cmd.status = ST_OK;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      // first-fit scan
      S_A_RD: begin
        if (sts.idx_end) begin
          cmd.done   = 1'b1;
          cmd.status = ST_NO_FIT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        if (sts.a_le1) begin
          state_nxt = S_A_PAD;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_A_PAD;
        end
      end
      S_A_PAD: begin
        cmd.pad_ld = 1'b1;
        state_nxt  = S_A_EX;
      end
      S_A_EX: begin
        if (sts.fit) begin
          cmd.alloc_upd = 1'b1;
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_ALLOC;
          if (sts.len_zero) begin
            cmd.erase_setup = 1'b1;
            state_nxt       = S_E_RD;
          end else begin
            cmd.done   = 1'b1;
            cmd.status = ST_OK;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_A_RD;
        end
      end
      // close the gap left by an emptied entry
      S_E_RD: begin
        if (sts.idx_end) begin
          cmd.cnt_dec = 1'b1;
          cmd.done    = 1'b1;
          cmd.status  = ST_OK;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_E_WR;
        end
      end
      S_E_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_Q;
        cmd.wp_inc  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_E_RD;
      end
      // find the insert position: after all starts not above the new one
      S_F_RD: begin
        if (sts.idx_end) begin
          cmd.pos_set = 1'b1;
          state_nxt   = S_S_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (sts.start_le) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_F_RD;
        end else begin
          cmd.pos_set = 1'b1;
          state_nxt   = S_S_RD;
        end
      end
      // shift entries up to open the slot
      S_S_RD: begin
        if (sts.wp_at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_INS;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_M_RD0;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_WPM1;
          state_nxt  = S_S_WR;
        end
      end
      S_S_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_Q;
        cmd.wp_dec = 1'b1;
        state_nxt  = S_S_RD;
      end
      // coalesce adjacent entries in one pass
      S_M_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_nxt  = S_M_LD;
      end
      S_M_LD: begin
        cmd.cur_ld   = 1'b1;
        cmd.mrg_init = 1'b1;
        state_nxt    = S_M_RD;
      end
      S_M_RD: begin
        if (sts.idx_end) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_CUR;
          cmd.cnt_wp1 = 1'b1;
          cmd.done    = 1'b1;
          cmd.status  = ST_OK;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_M_EX;
        end
      end
      S_M_EX: begin
        cmd.idx_inc = 1'b1;
        if (sts.adjacent) begin
          cmd.cur_merge = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_CUR;
          cmd.wp_inc = 1'b1;
          cmd.cur_ld = 1'b1;
        end
        state_nxt = S_M_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== sv/first_fit_range_allocator.sv =====
// Init, reset, unknown codes and rejected requests finish in the decode state;
// allocate scans entries in order, running the bit-serial remainder unit per
// entry for alignment above 1, and moves later entries down when an emptied
// entry is erased; free and grow run a position scan, a shift-up and a merge
// pass. One request at a time; next start taken in the strobe cycle.
// ----------------------------------------------------------------------------
// first_fit_range_allocator: first-fit free range allocator with coalescing
// Keeps the free ranges of a buffer sorted by offset; allocates with
// alignment, frees and grows with merging of adjacent ranges. The receiver
// cannot stall. Synchronous reset empties the list; list memory is not cleared.
// ----------------------------------------------------------------------------
module first_fit_range_allocator
  import ffra_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_opcode,
  input  logic [DW-1:0] in_size,
  input  logic [DW-1:0] in_alignment,
  input  logic [DW-1:0] in_range_offset,
  input  logic [DW-1:0] in_new_total_size,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [DW-1:0] cfg_wdata,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic [DW-1:0] out_granted_offset,
  output logic [DW-1:0] out_granted_size,
  output logic          out_was_hole,
  output logic [DW-1:0] out_allocated_bytes
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ffra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffra_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_opcode),
    .in_size             (in_size),
    .in_alignment        (in_alignment),
    .in_range_offset     (in_range_offset),
    .in_new_total_size   (in_new_total_size),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_offset  (out_granted_offset),
    .out_granted_size    (out_granted_size),
    .out_was_hole        (out_was_hole),
    .out_allocated_bytes (out_allocated_bytes)
  );

`ifndef SYNTHESIS
  // a result only follows the end of a request
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in progress");

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  // list occupancy stays within the memory depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cnt <= CNT_W'(MAX_RANGES))
    else $error("free list count beyond capacity");

  // a result strobe does not repeat unless a new start was presented with it
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid || $past(start))
    else $error("repeated result strobe");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for first_fit_range_allocator
// Drives init, reset, allocate, free and grow requests, with directed corner
// cases followed by mostly well-formed allocate/free traffic under several
// register settings and sender idle rates. A predictor kept in step with every
// accepted request computes each result, and a monitor checks the
// result strobe against it.
// ----------------------------------------------------------------------------
module testbench;
  import ffra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    opcode_t     op;
    logic [31:0] size;
    logic [31:0] align;
    logic [31:0] roff;
    logic [31:0] newsz;
  } request_t;

  typedef struct {
    status_t     st;
    logic [31:0] goff;
    logic [31:0] gsize;
    logic        hole;
    logic [31:0] taken;
  } grant_t;

  typedef struct {
    logic [31:0] off;
    logic [31:0] len;
  } span_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic [31:0] in_size = '0;
  logic [31:0] in_alignment = '0;
  logic [31:0] in_range_offset = '0;
  logic [31:0] in_new_total_size = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_granted_offset;
  logic [31:0] out_granted_size;
  logic        out_was_hole;
  logic [31:0] out_allocated_bytes;

  first_fit_range_allocator u_dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t pend_q[$];
  grant_t   grant_q[$];
  span_t    held_q[$];
  int       send_idle = 0;
  int       errors = 0;
  int       n_req = 0;
  int       n_res = 0;
  int       n_alloc_ok = 0;
  int       n_full = 0;

  // predictor state: free list, region and configuration
  logic [31:0] fr_start[MAX_RANGES];
  logic [31:0] fr_len[MAX_RANGES];
  int          fr_cnt = 0;
  logic [31:0] reg_start = '0, reg_len = '0, taken = '0;
  logic [31:0] c_base = '0, c_rsize = '0, c_ifree = '0;
  logic        c_whole = 1'b1;

  task automatic set_single(logic [31:0] s, logic [31:0] l);
    fr_cnt = 0;
    if (l != 0) begin
      fr_start[0] = s;
      fr_len[0] = l;
      fr_cnt = 1;
    end
  endtask

  task automatic erase_entry(int p);
    for (int i = p; i + 1 < fr_cnt; i++) begin
      fr_start[i] = fr_start[i+1];
      fr_len[i] = fr_len[i+1];
    end
    if (fr_cnt > 0) fr_cnt--;
  endtask

  task automatic insert_merge(logic [31:0] s, logic [31:0] l);
    int p;
    int i;
    logic [32:0] fin;
    logic [32:0] sum;
    p = 0;
    while (p < fr_cnt && fr_start[p] <= s) p++;
    for (i = fr_cnt; i > p; i--) begin
      fr_start[i] = fr_start[i-1];
      fr_len[i] = fr_len[i-1];
    end
    fr_start[p] = s;
    fr_len[p] = l;
    fr_cnt++;
    // coalesce neighbors whose combined length still fits 32 bits
    i = 0;
    while (i + 1 < fr_cnt) begin
      fin = {1'b0, fr_start[i]} + fr_len[i];
      sum = {1'b0, fr_len[i]} + fr_len[i+1];
      if ({1'b0, fr_start[i+1]} == fin && !sum[32]) begin
        fr_len[i] = sum[31:0];
        erase_entry(i + 1);
      end else begin
        i++;
      end
    end
  endtask

  task automatic predict_grant(input request_t r, output grant_t g);
    longint unsigned a, pad, need;
    logic last;
    g = '{st: ST_OK, goff: '0, gsize: '0, hole: 1'b0, taken: '0};
    case (r.op)
      OP_INIT: begin
        set_single(c_base, c_whole ? c_rsize : c_ifree);
        reg_start = c_base;
        reg_len = c_rsize;
        taken = c_base;
      end
      OP_RESET: begin
        set_single(reg_start, reg_len);
        taken = '0;
      end
      OP_ALLOC: begin
        if (r.size == 0) begin
          g.st = ST_ZERO_SIZE;
        end else begin
          a = (r.align == 0) ? 1 : r.align;
          g.st = ST_NO_FIT;
          for (int i = 0; i < fr_cnt; i++) begin
            pad = (a - (longint'(fr_start[i]) % a)) % a;
            need = longint'(r.size) + pad;
            if (need <= fr_len[i]) begin
              last = (i + 1 == fr_cnt);
              g.st = ST_OK;
              g.goff = fr_start[i] + pad[31:0];
              g.gsize = r.size;
              g.hole = !last;
              fr_start[i] = fr_start[i] + need[31:0];
              fr_len[i] = fr_len[i] - need[31:0];
              if (fr_len[i] == 0) erase_entry(i);
              if (last) taken = taken + r.size;
              break;
            end
          end
        end
      end
      OP_FREE: begin
        if (r.size == 0) g.st = ST_ZERO_SIZE;
        else if (fr_cnt >= MAX_RANGES) g.st = ST_LIST_FULL;
        else insert_merge(r.roff, r.size);
      end
      OP_GROW: begin
        if (r.newsz < reg_len) begin
          g.st = ST_GROW_SMALL;
        end else if (r.newsz != reg_len) begin
          if (fr_cnt >= MAX_RANGES) begin
            g.st = ST_LIST_FULL;
          end else begin
            insert_merge(reg_len, r.newsz - reg_len);
            reg_len = r.newsz;
          end
        end
      end
      default: ;
    endcase
    g.taken = taken;
  endtask

  // driver: accept, predict, then present the next request
  always @(posedge clk) begin
    logic     take;
    logic     nxt;
    grant_t   g;
    request_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        r = pend_q.pop_front();
        predict_grant(r, g);
        grant_q.push_back(g);
        n_req++;
        if (g.st == ST_OK && r.op == OP_ALLOC) begin
          n_alloc_ok++;
          if (held_q.size() < 48) held_q.push_back('{g.goff, g.gsize});
        end
        if (g.st == ST_LIST_FULL) n_full++;
      end
      nxt = start && !take;
      if (!nxt && pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        nxt = 1'b1;
        in_opcode <= pend_q[0].op;
        in_size <= pend_q[0].size;
        in_alignment <= pend_q[0].align;
        in_range_offset <= pend_q[0].roff;
        in_new_total_size <= pend_q[0].newsz;
      end
      start <= nxt;
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    errors++;
  endtask

  // monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid) begin
      n_res++;
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_status), 32'hx);
      end else begin
        g = grant_q.pop_front();
        if (out_status !== g.st) report_mismatch("status", 32'(out_status), 32'(g.st));
        if (out_granted_offset !== g.goff)
          report_mismatch("granted_offset", out_granted_offset, g.goff);
        if (out_granted_size !== g.gsize)
          report_mismatch("granted_size", out_granted_size, g.gsize);
        if (out_was_hole !== g.hole)
          report_mismatch("was_hole", 32'(out_was_hole), 32'(g.hole));
        if (out_allocated_bytes !== g.taken)
          report_mismatch("allocated_bytes", out_allocated_bytes, g.taken);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_req(opcode_t op, logic [31:0] sz, logic [31:0] al,
                          logic [31:0] ro, logic [31:0] nt);
    pend_q.push_back('{op: op, size: sz, align: al, roff: ro, newsz: nt});
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || grant_q.size() != 0 || start) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_OFFSET: c_base = d;
      CFG_REGION_SIZE: c_rsize = d;
      CFG_INIT_FREE:   c_ifree = d;
      default:         c_whole = d[0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_region(logic [31:0] b, logic [31:0] s, logic [31:0] f, logic w);
    wait_idle();
    write_cfg(CFG_BASE_OFFSET, b);
    write_cfg(CFG_REGION_SIZE, s);
    write_cfg(CFG_INIT_FREE, f);
    write_cfg(CFG_FREE_WHOLE, {31'b0, w});
    held_q.delete();
    push_req(OP_INIT, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [31:0] rand_align();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return $urandom;
      default: return 32'd1 << $urandom_range(6);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    return ($urandom_range(3) == 0) ? $urandom : $urandom_range(600);
  endfunction

  // mostly allocate/free traffic, plus some resets, grows and noise
  task automatic random_traffic(int count);
    int    k;
    int    sel;
    span_t s;
    for (int n = 0; n < count; n++) begin
      while (pend_q.size() >= 2) @(posedge clk);
      sel = $urandom_range(99);
      if (sel < 46) begin
        push_req(OP_ALLOC, ($urandom_range(30) == 0) ? 32'd0 : $urandom_range(1, 300),
                 rand_align(), $urandom, $urandom);
      end else if (sel < 78 && held_q.size() > 0) begin
        k = $urandom_range(held_q.size() - 1);
        s = held_q[k];
        held_q.delete(k);
        push_req(OP_FREE, s.len, $urandom, s.off, $urandom);
      end else if (sel < 84) begin
        push_req(OP_FREE, rand_word(), $urandom, $urandom, $urandom);
      end else if (sel < 90) begin
        push_req(OP_GROW, $urandom, $urandom, $urandom,
                 ($urandom_range(4) == 0) ? $urandom : reg_len + $urandom_range(0, 400));
      end else if (sel < 94) begin
        held_q.delete();
        push_req(OP_RESET, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 97) begin
        held_q.delete();
        push_req(OP_INIT, $urandom, $urandom, $urandom, $urandom);
      end else begin
        push_req(opcode_t'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int idle_set[4];
    idle_set = '{0, 77, 30, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases on an empty region
    setup_region(32'd0, 32'd0, 32'd0, 1'b1);
    push_req(OP_ALLOC, 32'd0, 32'd0, 32'd0, 32'd0);
    push_req(OP_ALLOC, 32'd8, 32'd0, 32'd0, 32'd0);
    push_req(OP_FREE, 32'd0, 32'd0, 32'd100, 32'd0);
    push_req(OP_FREE, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'd0);
    push_req(OP_FREE, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
    push_req(OP_FREE, 32'h20, 32'd0, 32'hFFFF_FFF0, 32'd0);
    push_req(OP_FREE, 32'h10, 32'd0, 32'h10, 32'd0);
    push_req(OP_FREE, 32'h4, 32'd0, 32'h10, 32'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
    push_req(OP_ALLOC, 32'd3, 32'd16, 32'd0, 32'd0);
    push_req(OP_ALLOC, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd0);
    push_req(OP_ALLOC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
    push_req(OP_GROW, 32'd0, 32'd0, 32'd0, 32'd0);
    push_req(OP_GROW, 32'd0, 32'd0, 32'd0, 32'd64);
    push_req(OP_GROW, 32'd0, 32'd0, 32'd0, 32'd10);
    push_req(OP_GROW, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    push_req(OP_RESET, 32'd0, 32'd0, 32'd0, 32'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    push_req(OP_ALLOC, 32'd1, 32'd2, 32'd0, 32'd0);
    push_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(3'd7, 32'd0, 32'd0, 32'd0, 32'd0);

    // fill the list to capacity, then overflow it with a free and a grow
    setup_region(32'd0, 32'd0, 32'd0, 1'b0);
    for (int i = 0; i <= MAX_RANGES; i++) begin
      while (pend_q.size() >= 2) @(posedge clk);
      push_req(OP_FREE, 32'd1, 32'd0, 32'(1000 + 4 * i), 32'd0);
    end
    push_req(OP_GROW, 32'd0, 32'd0, 32'd0, 32'd50);
    push_req(OP_ALLOC, 32'd1, 32'd8, 32'd0, 32'd0);

    // random phases over several region settings and sender idle rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: setup_region(32'd0, 32'd4096, 32'd1000, 1'b1);
        1: setup_region(32'h0000_1000, 32'h0001_0000, 32'h800, 1'b0);
        2: setup_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        default: setup_region($urandom, 32'd2048, 32'd0, 1'b1);
      endcase
      // hold the sender until every pending result is back
      wait_idle();
      send_idle = idle_set[ph];
      random_traffic(180);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d allocations granted, %0d list-full drops",
             n_req, n_res, n_alloc_ok, n_full);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
